>>> hdl/mcm_pkg.sv
// shared constants for the 4x4 matrix chain multiplier
`default_nettype none

package mcm_pkg;

   // width of every element port, fixed by the interface
   localparam int PORT_W = 32;
   // element columns carried on the ports
   localparam int NCOLS_IO = 4;
   // width of the row index port
   localparam int ROW_W = 2;

   typedef logic [PORT_W-1:0] port_word_type;

endpackage : mcm_pkg

`default_nettype wire

>>> hdl/mat4_chain_multiply.sv
// matrix chain multiplier: new product = incoming matrix times running product
// a row beat of the last matrix of a chain reaches rsp_ through the input register, then the result register
// throughput: one row per cycle, DIM*DIM multipliers work in parallel on each row
// stalls only when a row of the last matrix meets a full result register and rsp_ready is low
// reset (synchronous): row count and flags cleared, running product = identity
// the pending product is not reset, each of its rows is written before it is read
`default_nettype none

module mat4_chain_multiply
   import mcm_pkg::*;
#(
   parameter int ELEM_WIDTH = 32,
   parameter int FRAC_BITS  = 16,
   parameter int DIM        = 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,

   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic signed [PORT_W-1:0] req_elem0,
   input  wire logic signed [PORT_W-1:0] req_elem1,
   input  wire logic signed [PORT_W-1:0] req_elem2,
   input  wire logic signed [PORT_W-1:0] req_elem3,
   input  wire logic                     req_first_of_chain,
   input  wire logic                     req_last_of_chain,

   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [PORT_W-1:0]      rsp_res0,
   output logic signed [PORT_W-1:0]      rsp_res1,
   output logic signed [PORT_W-1:0]      rsp_res2,
   output logic signed [PORT_W-1:0]      rsp_res3,
   output logic [ROW_W-1:0]              rsp_row_number,
   output logic                          rsp_final_row
);

   localparam int EW    = (ELEM_WIDTH > 32) ? 32 : ((ELEM_WIDTH < 2) ? 2 : ELEM_WIDTH);
   localparam int RCW   = $clog2(DIM);
   localparam int PW    = 2 * EW;
   localparam int SUM_W = PW + RCW + 1;

   localparam logic signed [EW-1:0]    ELEM_MAX = {1'b0, {(EW-1){1'b1}}};
   localparam logic signed [EW-1:0]    ELEM_ONE = (FRAC_BITS >= EW - 1) ? ELEM_MAX
                                                  : (EW'(1) << FRAC_BITS);
   localparam logic signed [SUM_W-1:0] SUM_MAX  = {{(SUM_W-EW+1){1'b0}}, {(EW-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN  = ~SUM_MAX;
   localparam logic [RCW-1:0]          LAST_ROW = RCW'(DIM - 1);

   // input register
   logic                 in_valid_ff;
   logic signed [EW-1:0] in_elem_ff [DIM];
   logic                 in_first_ff;
   logic                 in_last_ff;

   // chain state
   logic [RCW-1:0]       row_cnt_ff;
   logic                 held_first_ff;
   logic                 held_last_ff;
   logic signed [EW-1:0] running_ff [DIM][DIM];
   logic signed [EW-1:0] pending_ff [DIM][DIM];

   // result register
   logic                 out_valid_ff;
   port_word_type        out_res_ff [NCOLS_IO];
   logic [ROW_W-1:0]     out_row_ff;
   logic                 out_final_ff;

   logic                 eff_first;
   logic                 eff_last;
   logic                 out_free;
   logic                 s1_go;
   logic                 req_take;
   logic signed [PORT_W-1:0] req_word [NCOLS_IO];
   logic signed [EW-1:0]     req_elem [DIM];
   logic signed [PW-1:0]     prod     [DIM][DIM];
   logic signed [PW-1:0]     trunc    [DIM][DIM];
   logic signed [SUM_W-1:0]  dot_sum  [DIM];
   logic signed [EW-1:0]     new_row  [DIM];

   // handshake
   assign eff_first = (row_cnt_ff == '0) ? in_first_ff : held_first_ff;
   assign eff_last  = (row_cnt_ff == '0) ? in_last_ff  : held_last_ff;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign s1_go     = in_valid_ff && (!eff_last || out_free);
   assign req_ready = !in_valid_ff || s1_go;
   assign req_take  = req_valid && req_ready;

   // input columns beyond the ports read as zero
   always_comb begin
      req_word[0] = req_elem0;
      req_word[1] = req_elem1;
      req_word[2] = req_elem2;
      req_word[3] = req_elem3;
      for (int j = 0; j < DIM; j++) begin
         if (j < NCOLS_IO) begin
            req_elem[j] = req_word[j % NCOLS_IO][EW-1:0];
         end else begin
            req_elem[j] = '0;
         end
      end
   end

   // one row of incoming matrix times running product
   always_comb begin
      for (int j = 0; j < DIM; j++) begin
         dot_sum[j] = '0;
         for (int k = 0; k < DIM; k++) begin
            prod[j][k]  = PW'(in_elem_ff[k]) * PW'(running_ff[k][j]);
            trunc[j][k] = prod[j][k] >>> FRAC_BITS;
            dot_sum[j]  = dot_sum[j] + SUM_W'(trunc[j][k]);
         end
         if (eff_first) begin
            new_row[j] = in_elem_ff[j];
         end else if (dot_sum[j] > SUM_MAX) begin
            new_row[j] = ELEM_MAX;
         end else if (dot_sum[j] < SUM_MIN) begin
            new_row[j] = ~ELEM_MAX;
         end else begin
            new_row[j] = dot_sum[j][EW-1:0];
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_take) begin
         in_elem_ff  <= req_elem;
         in_first_ff <= req_first_of_chain;
         in_last_ff  <= req_last_of_chain;
      end
   end

   // row count, held flags, running product
   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff    <= '0;
         held_first_ff <= 1'b0;
         held_last_ff  <= 1'b0;
         for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
               running_ff[i][j] <= (i == j) ? ELEM_ONE : '0;
            end
         end
      end else if (s1_go) begin
         held_first_ff <= eff_first;
         held_last_ff  <= eff_last;
         if (row_cnt_ff == LAST_ROW) begin
            row_cnt_ff <= '0;
            for (int i = 0; i < DIM; i++) begin
               if (i < DIM - 1) begin
                  running_ff[i] <= pending_ff[i];
               end else begin
                  running_ff[i] <= new_row;
               end
            end
         end else begin
            row_cnt_ff <= row_cnt_ff + RCW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         pending_ff[row_cnt_ff] <= new_row;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_go && eff_last) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (s1_go && eff_last) begin
         for (int j = 0; j < NCOLS_IO; j++) begin
            if (j < DIM) begin
               out_res_ff[j] <= PORT_W'($unsigned(new_row[j % DIM]));
            end else begin
               out_res_ff[j] <= '0;
            end
         end
         out_row_ff   <= ROW_W'(row_cnt_ff);
         out_final_ff <= (row_cnt_ff == LAST_ROW);
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_res0       = out_res_ff[0];
   assign rsp_res1       = out_res_ff[1];
   assign rsp_res2       = out_res_ff[2];
   assign rsp_res3       = out_res_ff[3];
   assign rsp_row_number = out_row_ff;
   assign rsp_final_row  = out_final_ff;

   // a row beat that has no result never fills the result register
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_go && !eff_last && out_free |=> !out_valid_ff)
      else $error("result register loaded by a beat without result");

   // a held row beat is not dropped
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !s1_go |=> in_valid_ff)
      else $error("input beat lost while stalled");

   // the last row of a matrix wraps the row count
   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      s1_go && row_cnt_ff == LAST_ROW |=> row_cnt_ff == '0)
      else $error("row count did not wrap after last row");

   // flags are taken from row 0 of each matrix
   a_flags_row0: assert property (@(posedge clock) disable iff (reset)
      s1_go && row_cnt_ff == '0 |=> held_first_ff == $past(in_first_ff)
                                     && held_last_ff == $past(in_last_ff))
      else $error("chain flags not captured on row 0");

endmodule : mat4_chain_multiply

`default_nettype wire
